[rtl/capsule_distance_field_top_assert.svh]
// Assertion macros for the capsule distance field block.
// Used by capsule_distance_field_top; relies on clk_i and rst_ni in scope.
`ifndef CAPSULE_DISTANCE_FIELD_TOP_ASSERT_SVH
`define CAPSULE_DISTANCE_FIELD_TOP_ASSERT_SVH

// Condition c must hold in the same cycle as a
`define CDF_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("cdf: assertion failed");

// Condition c must hold in the cycle after a
`define CDF_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("cdf: assertion failed");

`endif

[rtl/cdf_pkg.sv]
// Package for the capsule distance field block: widths, register codes,
// configuration and pipeline payload types. No dependencies.
package cdf_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;

  // APB data and address layout
  localparam int DataW    = (CoordWidth > 32) ? 64 : 32;
  localparam int AddrLsb  = (CoordWidth > 32) ? 3 : 2;
  localparam int RegCount = 7;
  localparam int IdxW     = $clog2(RegCount);
  localparam int AddrW    = IdxW + AddrLsb;
  localparam int RadiusW  = CoordWidth - 1;

  // Datapath widths
  localparam int DiffW = CoordWidth + 1;       // pa, ba (signed)
  localparam int MagW  = CoordWidth + 1;       // |pa|, |ba|
  localparam int ProdW = 2 * MagW;             // |pa|*|ba|, |ba|^2
  localparam int DotW  = ProdW + 2;            // sum of three products
  localparam int HW    = FracBits + 1;         // h, 0 .. 1.0
  localparam int PrjW  = MagW + HW;            // |ba|*h
  localparam int EW    = CoordWidth + 3;       // e (signed)
  localparam int EMagW = CoordWidth + 2;       // |e|
  localparam int SqW   = 2 * EMagW + 2;        // sum of squares
  localparam int RootW = SqW / 2;              // length
  localparam int RemW  = RootW + 2;            // root remainder
  localparam int DistW = RootW + 2;            // length - radius (signed)

  localparam logic [CoordWidth-1:0] OneFix = CoordWidth'(1) << FracBits;
  localparam logic [PrjW-1:0]       HalfLsb = PrjW'(1) << (FracBits - 1);
  localparam logic [HW-1:0]         HOne = HW'(1) << FracBits;

  typedef enum logic [IdxW-1:0] {
    RegStartX = 3'd0,
    RegStartY = 3'd1,
    RegStartZ = 3'd2,
    RegEndX   = 3'd3,
    RegEndY   = 3'd4,
    RegEndZ   = 3'd5,
    RegRadius = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] start_x;
    logic signed [CoordWidth-1:0] start_y;
    logic signed [CoordWidth-1:0] start_z;
    logic signed [CoordWidth-1:0] end_x;
    logic signed [CoordWidth-1:0] end_y;
    logic signed [CoordWidth-1:0] end_z;
    logic [RadiusW-1:0]           radius;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    start_x: '0, start_y: '0, start_z: '0,
    end_x: '0, end_y: '0, end_z: OneFix,
    radius: OneFix[RadiusW-1:0]
  };

  // Per-axis differences that travel with an item
  typedef struct packed {
    logic [2:0][DiffW-1:0] pa;
    logic [2:0][DiffW-1:0] ba;
  } geom_t;

endpackage

[rtl/cdf_if.sv]
// Stream interfaces of the capsule distance field block: query points in,
// distances out. Depends on cdf_pkg.
interface cdf_point_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cdf_pkg::CoordWidth-1:0] point_x;
  logic signed [cdf_pkg::CoordWidth-1:0] point_y;
  logic signed [cdf_pkg::CoordWidth-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface cdf_dist_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cdf_pkg::CoordWidth-1:0] signed_distance;

  modport source (output valid, signed_distance, input ready);
  modport sink   (input valid, signed_distance, output ready);
endinterface

[rtl/cdf_cfg.sv]
// APB register file for the capsule endpoints and radius.
// Depends on cdf_pkg.
module cdf_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cdf_pkg::AddrW-1:0]    paddr,
  input  logic [cdf_pkg::DataW-1:0]    pwdata,
  output logic [cdf_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output cdf_pkg::cfg_t                cfg_o
);

  cdf_pkg::cfg_t     cfg_q;
  cdf_pkg::cfg_reg_e idx;

  assign idx    = cdf_pkg::cfg_reg_e'(paddr[cdf_pkg::AddrW-1:cdf_pkg::AddrLsb]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes on the access phase; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cdf_pkg::CfgReset;
    end else if (psel && penable && pwrite) begin
      case (idx)
        cdf_pkg::RegStartX: cfg_q.start_x <= pwdata[cdf_pkg::CoordWidth-1:0];
        cdf_pkg::RegStartY: cfg_q.start_y <= pwdata[cdf_pkg::CoordWidth-1:0];
        cdf_pkg::RegStartZ: cfg_q.start_z <= pwdata[cdf_pkg::CoordWidth-1:0];
        cdf_pkg::RegEndX:   cfg_q.end_x   <= pwdata[cdf_pkg::CoordWidth-1:0];
        cdf_pkg::RegEndY:   cfg_q.end_y   <= pwdata[cdf_pkg::CoordWidth-1:0];
        cdf_pkg::RegEndZ:   cfg_q.end_z   <= pwdata[cdf_pkg::CoordWidth-1:0];
        cdf_pkg::RegRadius: cfg_q.radius  <= pwdata[cdf_pkg::RadiusW-1:0];
        default: ;
      endcase
    end
  end

  // read-back, zero-extended
  always_comb begin
    case (idx)
      cdf_pkg::RegStartX: prdata = cdf_pkg::DataW'($unsigned(cfg_q.start_x));
      cdf_pkg::RegStartY: prdata = cdf_pkg::DataW'($unsigned(cfg_q.start_y));
      cdf_pkg::RegStartZ: prdata = cdf_pkg::DataW'($unsigned(cfg_q.start_z));
      cdf_pkg::RegEndX:   prdata = cdf_pkg::DataW'($unsigned(cfg_q.end_x));
      cdf_pkg::RegEndY:   prdata = cdf_pkg::DataW'($unsigned(cfg_q.end_y));
      cdf_pkg::RegEndZ:   prdata = cdf_pkg::DataW'($unsigned(cfg_q.end_z));
      cdf_pkg::RegRadius: prdata = cdf_pkg::DataW'(cfg_q.radius);
      default:            prdata = '0;
    endcase
  end

endmodule

[rtl/cdf_div.sv]
// Pipelined restoring divider for the projection parameter h, one quotient
// bit per stage; carries the item's geometry alongside. Depends on cdf_pkg.
module cdf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [cdf_pkg::DotW-1:0]    num_i,
  input  logic [cdf_pkg::DotW-1:0]    den_i,
  input  logic                        zero_i,
  input  logic                        one_i,
  input  cdf_pkg::geom_t              geom_i,
  output logic                        valid_o,
  output logic [cdf_pkg::HW-1:0]      h_o,
  output cdf_pkg::geom_t              geom_o
);

  localparam int N = cdf_pkg::FracBits;
  localparam int D = cdf_pkg::DotW;

  logic [N-1:0]   vld_q;
  logic [N-1:0]   zero_q;
  logic [N-1:0]   one_q;
  logic [D-1:0]   rem_q [N];
  logic [D-1:0]   den_q [N];
  logic [N-1:0]   quo_q [N];
  cdf_pkg::geom_t geom_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic           vld_in, zero_in, one_in, ge;
    logic [D-1:0]   rem_in, den_in, rem_d;
    logic [N-1:0]   quo_in;
    logic [D:0]     r2, diff;
    cdf_pkg::geom_t geom_in;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign zero_in = zero_i;
      assign one_in  = one_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign geom_in = geom_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign zero_in = zero_q[k-1];
      assign one_in  = one_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign geom_in = geom_q[k-1];
    end

    // shift in a zero, subtract the divisor if it fits
    always_comb begin
      r2    = {rem_in, 1'b0};
      diff  = r2 - {1'b0, den_in};
      ge    = (r2 >= {1'b0, den_in});
      rem_d = ge ? diff[D-1:0] : r2[D-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[k] <= zero_in;
        one_q[k]  <= one_in;
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quo_q[k]  <= {quo_in[N-2:0], ge};
        geom_q[k] <= geom_in;
      end
    end
  end

  // clamp cases override the quotient
  assign valid_o = vld_q[N-1];
  assign geom_o  = geom_q[N-1];
  assign h_o     = zero_q[N-1] ? '0 :
                   one_q[N-1]  ? cdf_pkg::HOne : {1'b0, quo_q[N-1]};

endmodule

[rtl/cdf_sqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage,
// truncating. Depends on cdf_pkg.
module cdf_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [cdf_pkg::SqW-1:0]     sq_i,
  output logic                        valid_o,
  output logic [cdf_pkg::RootW-1:0]   root_o
);

  localparam int N = cdf_pkg::RootW;
  localparam int S = cdf_pkg::SqW;
  localparam int R = cdf_pkg::RemW;

  logic [N-1:0] vld_q;
  logic [R-1:0] rem_q [N];
  logic [N-1:0] root_q [N];
  logic [S-1:0] rad_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic         vld_in, ge;
    logic [R-1:0] rem_in, rem_d;
    logic [N-1:0] root_in;
    logic [S-1:0] rad_in;
    logic [R+1:0] cur, trial, diff;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sq_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // bring down two bits, try root*4+1
    always_comb begin
      cur   = {rem_in, rad_in[S-1:S-2]};
      trial = (R + 2)'({root_in, 2'b01});
      diff  = cur - trial;
      ge    = (cur >= trial);
      rem_d = ge ? diff[R-1:0] : cur[R-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= {root_in[N-2:0], ge};
        rad_q[k]  <= {rad_in[S-3:0], 2'b00};
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];

endmodule

[rtl/capsule_distance_field_top.sv]
// Capsule distance field: one query point per clock in, one Q16.16 signed
// distance per clock out, in order, while the skid stage is empty. The path
// runs through the h divider (one quotient bit per stage), the square root
// (one root bit per stage), and eleven product, sum, saturation and output
// stages around them. Throughput is one point per cycle while the skid stage
// is empty; an output register plus a one-entry skid stage let the pipeline
// take one more point after the sink stalls. Endpoints and radius are APB
// registers at byte addresses 0..24 and must only change while no point
// is in flight. Depends on cdf_pkg, cdf_if, cdf_cfg, cdf_div, cdf_sqrt.
`include "capsule_distance_field_top_assert.svh"

module capsule_distance_field_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cdf_pkg::AddrW-1:0]    paddr,
  input  logic [cdf_pkg::DataW-1:0]    pwdata,
  output logic [cdf_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  cdf_point_if.sink                    point_i,
  cdf_dist_if.source                   result_o
);

  localparam int W = cdf_pkg::CoordWidth;
  localparam int F = cdf_pkg::FracBits;

  cdf_pkg::cfg_t cfg;
  logic          en;

  cdf_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // whole pipeline advances while the skid stage is free
  logic skid_valid_q;
  assign en            = !skid_valid_q;
  assign point_i.ready = en;

  // S1: differences from the start point
  logic                        v1_q;
  cdf_pkg::geom_t              geo1_q, geo1_d;
  logic signed [W-1:0]         pt [3];
  logic signed [W-1:0]         st [3];
  logic signed [W-1:0]         ed [3];

  assign pt[0] = point_i.point_x; assign pt[1] = point_i.point_y;
  assign pt[2] = point_i.point_z;
  assign st[0] = cfg.start_x; assign st[1] = cfg.start_y; assign st[2] = cfg.start_z;
  assign ed[0] = cfg.end_x;   assign ed[1] = cfg.end_y;   assign ed[2] = cfg.end_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      geo1_d.pa[i] = cdf_pkg::DiffW'($signed(pt[i])) - cdf_pkg::DiffW'($signed(st[i]));
      geo1_d.ba[i] = cdf_pkg::DiffW'($signed(ed[i])) - cdf_pkg::DiffW'($signed(st[i]));
    end
  end

  // S2: per-axis products of magnitudes
  logic                         v2_q;
  cdf_pkg::geom_t               geo2_q;
  logic [cdf_pkg::ProdW-1:0]    pp2_q [3], pp2_d [3];
  logic [cdf_pkg::ProdW-1:0]    bb2_q [3], bb2_d [3];
  logic [2:0]                   neg2_q, neg2_d;
  logic [cdf_pkg::MagW-1:0]     mpa [3], mba [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mpa[i]    = geo1_q.pa[i][cdf_pkg::DiffW-1] ? -geo1_q.pa[i] : geo1_q.pa[i];
      mba[i]    = geo1_q.ba[i][cdf_pkg::DiffW-1] ? -geo1_q.ba[i] : geo1_q.ba[i];
      pp2_d[i]  = cdf_pkg::ProdW'(mpa[i]) * cdf_pkg::ProdW'(mba[i]);
      bb2_d[i]  = cdf_pkg::ProdW'(mba[i]) * cdf_pkg::ProdW'(mba[i]);
      neg2_d[i] = geo1_q.pa[i][cdf_pkg::DiffW-1] ^ geo1_q.ba[i][cdf_pkg::DiffW-1];
    end
  end

  // S3: split dot product into positive and negative sums, and |ba|^2
  logic                       v3_q;
  cdf_pkg::geom_t             geo3_q;
  logic [cdf_pkg::DotW-1:0]   pos3_q, pos3_d, neg3_q, neg3_d, den3_q, den3_d;

  always_comb begin
    pos3_d = '0;
    neg3_d = '0;
    den3_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (neg2_q[i]) neg3_d = neg3_d + cdf_pkg::DotW'(pp2_q[i]);
      else           pos3_d = pos3_d + cdf_pkg::DotW'(pp2_q[i]);
      den3_d = den3_d + cdf_pkg::DotW'(bb2_q[i]);
    end
  end

  // S4: net numerator; h is zero for a degenerate segment or non-positive dot
  logic                       v4_q, hz4_q, hz4_d;
  cdf_pkg::geom_t             geo4_q;
  logic [cdf_pkg::DotW-1:0]   num4_q, den4_q;
  logic [cdf_pkg::DotW:0]     net4;

  assign net4  = {1'b0, pos3_q} - {1'b0, neg3_q};
  assign hz4_d = (den3_q == '0) || net4[cdf_pkg::DotW] || (net4 == '0);

  // S5: clamp to one when the numerator reaches the denominator
  logic                       v5_q, hz5_q, ho5_q;
  cdf_pkg::geom_t             geo5_q;
  logic [cdf_pkg::DotW-1:0]   num5_q, den5_q;

  // divider
  logic                       vdv;
  logic [cdf_pkg::HW-1:0]     hdv;
  cdf_pkg::geom_t             geodv;

  cdf_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q), .num_i(num5_q), .den_i(den5_q),
    .zero_i(hz5_q), .one_i(ho5_q), .geom_i(geo5_q),
    .valid_o(vdv), .h_o(hdv), .geom_o(geodv)
  );

  // S6: |ba| * h
  logic                       v6_q;
  cdf_pkg::geom_t             geo6_q;
  logic [cdf_pkg::PrjW-1:0]   prj6_q [3], prj6_d [3];
  logic [cdf_pkg::MagW-1:0]   mbd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mbd[i]    = geodv.ba[i][cdf_pkg::DiffW-1] ? -geodv.ba[i] : geodv.ba[i];
      prj6_d[i] = cdf_pkg::PrjW'(mbd[i]) * cdf_pkg::PrjW'(hdv);
    end
  end

  // S7: round projection to nearest, ties away, and form e = pa - ba*h
  logic                       v7_q;
  logic [cdf_pkg::EW-1:0]     e7_q [3], e7_d [3];
  logic [cdf_pkg::PrjW:0]     rnd [3];
  logic [cdf_pkg::EW-1:0]     qv [3];
  logic [cdf_pkg::EW-1:0]     pav [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = {1'b0, prj6_q[i]} + {1'b0, cdf_pkg::HalfLsb};
      qv[i]  = cdf_pkg::EW'(rnd[i][cdf_pkg::PrjW:F]);
      pav[i] = cdf_pkg::EW'($signed(geo6_q.pa[i]));
      e7_d[i] = geo6_q.ba[i][cdf_pkg::DiffW-1] ? pav[i] + qv[i] : pav[i] - qv[i];
    end
  end

  // S8: squares of |e|
  logic                          v8_q;
  logic [2*cdf_pkg::EMagW-1:0]   sq8_q [3], sq8_d [3];
  logic [cdf_pkg::EW-1:0]        eneg [3];
  logic [cdf_pkg::EMagW-1:0]     emag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eneg[i]  = -e7_q[i];
      emag[i]  = e7_q[i][cdf_pkg::EW-1] ? eneg[i][cdf_pkg::EMagW-1:0]
                                         : e7_q[i][cdf_pkg::EMagW-1:0];
      sq8_d[i] = (2 * cdf_pkg::EMagW)'(emag[i]) * (2 * cdf_pkg::EMagW)'(emag[i]);
    end
  end

  // S9: sum of squares
  logic                       v9_q;
  logic [cdf_pkg::SqW-1:0]    sum9_q, sum9_d;

  assign sum9_d = cdf_pkg::SqW'(sq8_q[0]) + cdf_pkg::SqW'(sq8_q[1])
                + cdf_pkg::SqW'(sq8_q[2]);

  // square root
  logic                        vrt;
  logic [cdf_pkg::RootW-1:0]   root;

  cdf_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v9_q), .sq_i(sum9_q),
    .valid_o(vrt), .root_o(root)
  );

  // S10: subtract radius and saturate
  logic                          v10_q;
  logic signed [W-1:0]           sat10_q, sat10_d;
  logic signed [cdf_pkg::DistW-1:0] len_diff;
  localparam logic signed [cdf_pkg::DistW-1:0] LimHi =
    cdf_pkg::DistW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [cdf_pkg::DistW-1:0] LimLo = -LimHi - 1;

  always_comb begin
    len_diff = $signed(cdf_pkg::DistW'(root)) - $signed(cdf_pkg::DistW'(cfg.radius));
    if (len_diff > LimHi)      sat10_d = LimHi[W-1:0];
    else if (len_diff < LimLo) sat10_d = LimLo[W-1:0];
    else                       sat10_d = len_diff[W-1:0];
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0;
    end else if (en) begin
      v1_q <= point_i.valid;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
      v6_q <= vdv;  v7_q <= v6_q; v8_q <= v7_q; v9_q <= v8_q;
      v10_q <= vrt;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      geo1_q <= geo1_d;
      geo2_q <= geo1_q;
      pp2_q  <= pp2_d;
      bb2_q  <= bb2_d;
      neg2_q <= neg2_d;
      geo3_q <= geo2_q;
      pos3_q <= pos3_d;
      neg3_q <= neg3_d;
      den3_q <= den3_d;
      geo4_q <= geo3_q;
      num4_q <= net4[cdf_pkg::DotW-1:0];
      den4_q <= den3_q;
      hz4_q  <= hz4_d;
      geo5_q <= geo4_q;
      num5_q <= num4_q;
      den5_q <= den4_q;
      hz5_q  <= hz4_q;
      ho5_q  <= !hz4_q && (num4_q >= den4_q);
      geo6_q <= geodv;
      prj6_q <= prj6_d;
      e7_q   <= e7_d;
      sq8_q  <= sq8_d;
      sum9_q <= sum9_d;
      sat10_q <= sat10_d;
    end
  end

  // output register with skid stage
  logic                 out_valid_q, take, res_v;
  logic signed [W-1:0]  out_data_q, skid_data_q;

  assign res_v = en && v10_q;
  assign take  = result_o.ready || !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_v;
      end
    end else if (res_v) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) out_data_q <= skid_data_q;
      else if (res_v)   out_data_q <= sat10_q;
    end else if (res_v) begin
      skid_data_q <= sat10_q;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.signed_distance = out_data_q;

  // checks
  `CDF_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
  `CDF_ASSERT_NEXT(a_stall_to_skid, res_v && !take, skid_valid_q)
  `CDF_ASSERT_NEXT(a_skid_drains, skid_valid_q && take, out_valid_q && !skid_valid_q)
  `CDF_ASSERT_NOW(a_dist_floor, out_valid_q, $signed(out_data_q) >= -$signed({1'b0, cfg.radius}))

endmodule
